@@ src/cbm_pkg.sv @@
// Package for the cartridge bank mapper: codes, limits and shared structs.
// Depends on nothing; every other file of the block imports it.
package cbm_pkg;

    // Largest bank counts the mapper supports.
    localparam logic [9:0] MAX_ROM_BANKS = 10'd512;
    localparam logic [4:0] MAX_RAM_BANKS = 5'd16;

    // Controller kinds (configuration register 0).
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_MBC1 = 3'd1;
    localparam logic [2:0] KIND_MBC2 = 3'd2;
    localparam logic [2:0] KIND_MBC3 = 3'd3;
    localparam logic [2:0] KIND_MBC5 = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_KIND      = 2'd0;
    localparam logic [1:0] CFG_ROM_COUNT = 2'd1;
    localparam logic [1:0] CFG_RAM_COUNT = 2'd2;
    localparam logic [1:0] CFG_BATTERY   = 2'd3;

    // Result targets.
    localparam logic [2:0] TGT_NONE      = 3'd0;
    localparam logic [2:0] TGT_ROM_READ  = 3'd1;
    localparam logic [2:0] TGT_RAM_READ  = 3'd2;
    localparam logic [2:0] TGT_RAM_WRITE = 3'd3;
    localparam logic [2:0] TGT_OPEN_BUS  = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_BANK  = 2'd1;
    localparam logic [1:0] ST_OUT_BOUND = 2'd2;

    // Data value that enables external RAM (low nibble).
    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    typedef struct packed {
        logic [2:0] kind;
        logic [9:0] rom_count;
        logic [4:0] ram_count;
        logic       battery;
    } t_cfg;

    typedef struct packed {
        logic       ram_enabled;
        logic [8:0] rom_page;
        logic [3:0] ram_bank;
        logic       advanced_mode;
        logic       ram_dirty;
    } t_bank_state;

    typedef struct packed {
        logic        mode;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } t_access;

    typedef struct packed {
        logic [2:0]  target;
        logic [22:0] phys_address;
        logic [7:0]  ram_write_byte;
        logic [1:0]  status;
        logic        save_request;
    } t_result;

endpackage

@@ src/cbm_access_if.sv @@
// Request channel carrying one CPU bus access into the bank mapper.
// Depends on cbm_pkg for nothing but style consistency of field widths.
interface cbm_access_if;
    import cbm_pkg::*;

    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;

    modport source (output valid, output mode, output bus_address, output write_data,
                    input ready);
    modport sink   (input valid, input mode, input bus_address, input write_data,
                    output ready);
endinterface

@@ src/cbm_result_if.sv @@
// Request channel carrying one mapping result out of the bank mapper.
// Field widths follow the result struct of cbm_pkg.
interface cbm_result_if;
    import cbm_pkg::*;

    logic        valid;
    logic        ready;
    logic [2:0]  target;
    logic [22:0] phys_address;
    logic [7:0]  ram_write_byte;
    logic [1:0]  status;
    logic        save_request;

    modport source (output valid, output target, output phys_address,
                    output ram_write_byte, output status, output save_request,
                    input ready);
    modport sink   (input valid, input target, input phys_address,
                    input ram_write_byte, input status, input save_request,
                    output ready);
endinterface

@@ src/cbm_decode.sv @@
// Combinational mapping of one access: bank register writes and address translation.
// Depends on cbm_pkg for the configuration, state, access and result structs.
module cbm_decode (
    input  cbm_pkg::t_cfg        i_cfg,
    input  cbm_pkg::t_bank_state i_state,
    input  cbm_pkg::t_access     i_acc,
    output cbm_pkg::t_bank_state o_next,
    output cbm_pkg::t_result     o_res
);
    import cbm_pkg::*;

    logic [9:0] w_rom_cnt;
    logic [4:0] w_ram_cnt;
    logic       w_en;
    logic [7:0] w_d;
    logic [15:0] w_a;
    logic [4:0] w_nz5;
    logic [3:0] w_nz4;
    logic [6:0] w_nz7;
    logic       w_rom_req;
    logic [8:0] w_rom_val;
    logic       w_ram_req;
    logic [3:0] w_ram_val;

    assign w_rom_cnt = (i_cfg.rom_count > MAX_ROM_BANKS) ? MAX_ROM_BANKS : i_cfg.rom_count;
    assign w_ram_cnt = (i_cfg.ram_count > MAX_RAM_BANKS) ? MAX_RAM_BANKS : i_cfg.ram_count;
    assign w_d       = i_acc.write_data;
    assign w_a       = i_acc.bus_address;
    assign w_en      = (w_d[3:0] == RAM_ENABLE_KEY);
    // A zero bank field selects bank 1 on MBC1, MBC2 and MBC3.
    assign w_nz5     = (w_d[4:0] == 5'd0) ? 5'd1 : w_d[4:0];
    assign w_nz4     = (w_d[3:0] == 4'd0) ? 4'd1 : w_d[3:0];
    assign w_nz7     = (w_d[6:0] == 7'd0) ? 7'd1 : w_d[6:0];

    always_comb begin
        o_next    = i_state;
        o_res     = '0;
        w_rom_req = 1'b0;
        w_rom_val = i_state.rom_page;
        w_ram_req = 1'b0;
        w_ram_val = '0;

        if (!w_a[15]) begin
            if (i_acc.mode) begin
                case (i_cfg.kind)
                    KIND_MBC1: begin
                        case (w_a[14:13])
                            2'd0: o_next.ram_enabled = w_en;
                            2'd1: begin
                                w_rom_req = 1'b1;
                                w_rom_val = {i_state.rom_page[8:5], w_nz5};
                            end
                            2'd2: begin
                                if (i_state.advanced_mode) begin
                                    if (w_ram_cnt == 5'd4) begin
                                        w_ram_req = 1'b1;
                                        w_ram_val = {2'b00, w_d[1:0]};
                                    end else if (w_rom_cnt > 10'd32) begin
                                        w_rom_req = 1'b1;
                                        w_rom_val = {i_state.rom_page[8:7], w_d[1:0],
                                                     i_state.rom_page[4:0]};
                                    end
                                end
                            end
                            default: begin
                                o_next.advanced_mode = w_d[0];
                                if (w_d[0] && (w_ram_cnt == 5'd4)) begin
                                    w_ram_req = 1'b1;
                                    w_ram_val = {2'b00, w_d[1:0]};
                                end
                            end
                        endcase
                    end
                    KIND_MBC2: begin
                        if (!w_a[14]) begin
                            if (w_a[8]) begin
                                w_rom_req = 1'b1;
                                w_rom_val = {5'd0, w_nz4};
                            end else begin
                                o_next.ram_enabled = w_en;
                            end
                        end
                    end
                    KIND_MBC3: begin
                        case (w_a[14:13])
                            2'd0: o_next.ram_enabled = w_en;
                            2'd1: begin
                                w_rom_req = 1'b1;
                                w_rom_val = {2'b00, w_nz7};
                            end
                            2'd2: begin
                                if (w_d <= 8'd3) begin
                                    w_ram_req = 1'b1;
                                    w_ram_val = {2'b00, w_d[1:0]};
                                end
                            end
                            default: ;
                        endcase
                    end
                    KIND_MBC5: begin
                        case (w_a[14:13])
                            2'd0: o_next.ram_enabled = w_en;
                            2'd1: begin
                                w_rom_req = 1'b1;
                                if (!w_a[12]) begin
                                    w_rom_val = {i_state.rom_page[8], w_d};
                                end else begin
                                    w_rom_val = {w_d[0], i_state.rom_page[7:0]};
                                end
                            end
                            2'd2: begin
                                w_ram_req = 1'b1;
                                w_ram_val = w_d[3:0];
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase

                // Out-of-range bank numbers are rejected and leave the bank as it was.
                if (w_rom_req) begin
                    if ({1'b0, w_rom_val} >= w_rom_cnt) begin
                        o_res.status = ST_BAD_BANK;
                    end else begin
                        o_next.rom_page = w_rom_val;
                    end
                end
                if (w_ram_req) begin
                    if ({1'b0, w_ram_val} >= w_ram_cnt) begin
                        o_res.status = ST_BAD_BANK;
                    end else begin
                        o_next.ram_bank    = w_ram_val;
                        o_res.save_request = i_cfg.battery & i_state.ram_dirty;
                    end
                end
            end else begin
                o_res.target = TGT_ROM_READ;
                if (w_a[14]) begin
                    o_res.phys_address = {i_state.rom_page, w_a[13:0]};
                end else begin
                    o_res.phys_address = {9'd0, w_a[13:0]};
                end
            end
        end else if (w_a[15:13] == 3'b101) begin
            if (!(i_state.ram_enabled && (w_ram_cnt != 5'd0))) begin
                o_res.target = i_acc.mode ? TGT_NONE : TGT_OPEN_BUS;
            end else begin
                o_res.phys_address = {6'd0, i_state.ram_bank, w_a[12:0]};
                if (i_acc.mode) begin
                    o_res.target         = TGT_RAM_WRITE;
                    o_res.ram_write_byte = w_d;
                    if (i_cfg.battery) begin
                        o_next.ram_dirty = 1'b1;
                    end
                end else begin
                    o_res.target = TGT_RAM_READ;
                end
            end
        end else begin
            o_res.status = ST_OUT_BOUND;
        end
    end

endmodule

@@ src/cbm_bank_regs.sv @@
// Bank state registers of the mapper: RAM enable, ROM and RAM bank, mode and dirty mark.
// Depends on cbm_pkg for the bank state struct.
module cbm_bank_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_update,
    input  cbm_pkg::t_bank_state i_next,
    output cbm_pkg::t_bank_state o_state
);
    import cbm_pkg::*;

    t_bank_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.ram_enabled   <= 1'b0;
            r_state.rom_page      <= 9'd1;
            r_state.ram_bank      <= 4'd0;
            r_state.advanced_mode <= 1'b0;
            r_state.ram_dirty     <= 1'b0;
        end else if (i_update) begin
            r_state <= i_next;
        end
    end

    assign o_state = r_state;

endmodule

@@ src/cartridge_bank_mapper.sv @@
// Top level of the cartridge bank mapper: input register, decode and result register.
// Depends on cbm_pkg, cbm_access_if, cbm_result_if, cbm_decode and cbm_bank_regs.
//
// Usage: each request on i_acc is one CPU bus access (mode, bus_address,
// write_data). For every accepted request exactly one result request leaves on
// o_res, in order, with the target (ROM read, RAM read, RAM write, open bus or
// none), the physical byte address, the byte to store, a status and a save flag.
// Writes below 0x8000 program the bank registers; the new banks apply to the
// very next access.
// An accepted request sits in the input register; when the result register can
// take a value, the decode and bank update land in the result register.
// Throughput is one access per cycle while the receiver does not stall,
// set by the single decode pass between those two registers; the bank state is
// updated in the same cycle the result is registered, so back-to-back accesses
// see each other's writes.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; after that i_acc.ready drops until o_res moves.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data while idle.
// Synchronous active-low reset empties both registers, restores the bank
// state (ROM bank 1, RAM disabled, bank 0, simple mode, clean) and the
// configuration defaults (no banking, 2 ROM banks, no RAM, no battery).
module cartridge_bank_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    cbm_access_if.sink  i_acc,
    cbm_result_if.source o_res
);
    import cbm_pkg::*;

    t_cfg        r_cfg;
    t_access     r_acc;
    logic        r_in_vld;
    t_result     r_res;
    logic        r_out_vld;
    t_bank_state w_state;
    t_bank_state w_next;
    t_result     w_res;
    logic        w_adv;
    logic        w_in_ready;

    // The result register can take a new value when it is empty or being drained.
    assign w_adv      = !r_out_vld || o_res.ready;
    assign w_in_ready = !r_in_vld || w_adv;
    assign i_acc.ready = w_in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kind      <= KIND_NONE;
            r_cfg.rom_count <= 10'd2;
            r_cfg.ram_count <= 5'd0;
            r_cfg.battery   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KIND:      r_cfg.kind      <= i_cfg_data[2:0];
                CFG_ROM_COUNT: r_cfg.rom_count <= i_cfg_data;
                CFG_RAM_COUNT: r_cfg.ram_count <= i_cfg_data[4:0];
                CFG_BATTERY:   r_cfg.battery   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Valid bits of the two pipeline registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_vld <= i_acc.valid;
            end
            if (w_adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_acc.valid && w_in_ready) begin
            r_acc.mode        <= i_acc.mode;
            r_acc.bus_address <= i_acc.bus_address;
            r_acc.write_data  <= i_acc.write_data;
        end
        if (w_adv && r_in_vld) begin
            r_res <= w_res;
        end
    end

    cbm_decode u_decode (
        .i_cfg   (r_cfg),
        .i_state (w_state),
        .i_acc   (r_acc),
        .o_next  (w_next),
        .o_res   (w_res)
    );

    // The bank state moves only when the access in the input register is retired.
    cbm_bank_regs u_bank_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_adv && r_in_vld),
        .i_next   (w_next),
        .o_state  (w_state)
    );

    assign o_res.valid          = r_out_vld;
    assign o_res.target         = r_res.target;
    assign o_res.phys_address   = r_res.phys_address;
    assign o_res.ram_write_byte = r_res.ram_write_byte;
    assign o_res.status         = r_res.status;
    assign o_res.save_request   = r_res.save_request;

    // A rejected bank number or an unmapped address never reaches a store.
    a_status_no_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_res.status != ST_OK)) |-> (r_res.target == TGT_NONE))
        else $error("result with error status carries a target");

    // The dirty mark is set only by a retired RAM write.
    a_dirty_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_state.ram_dirty) |->
            $past(w_adv && r_in_vld && (w_res.target == TGT_RAM_WRITE)))
        else $error("dirty mark set without a RAM write");

    // A result appears only for an access that sat in the input register.
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_in_vld))
        else $error("result valid without an accepted access");

endmodule

@@ dv/cartridge_bank_mapper_tb.sv @@
`timescale 1ns / 100ps
// Testbench for cartridge_bank_mapper: directed and random bus accesses under varying stalls,
// checked against an in-bench prediction of the bank registers and the address mapping.
// Depends on cbm_pkg, cbm_access_if, cbm_result_if and the cartridge_bank_mapper RTL.
module cartridge_bank_mapper_tb;
    import cbm_pkg::*;

    // Access directions and the controller kind that decodes no register writes at all.
    localparam logic       MODE_READ   = 1'b0;
    localparam logic       MODE_WRITE  = 1'b1;
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    // Cycles waited after the last result of each drain, so that the block settles.
    localparam int unsigned SETTLE_CYCLES = 4;
    // Longest sender gap, so that a high idle rate cannot starve the run.
    localparam int unsigned MAX_GAP = 40;
    // Only this many mismatch lines are printed; the count keeps going.
    localparam int unsigned MAX_REPORTS = 60;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [9:0] i_cfg_data;

    cbm_access_if acc_if ();
    cbm_result_if res_if ();

    cartridge_bank_mapper u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (acc_if),
        .o_res       (res_if)
    );

    // Predicted configuration and bank state. They only move when the bench writes a
    // register or when an access request is accepted, so they track the block exactly.
    t_cfg        cfg_m;
    t_bank_state bank_m;
    logic        save_pending;

    // Mapping results that have been predicted but not yet seen on the result channel.
    t_result     expected_results [$];
    t_result     want;
    t_result     got;
    int unsigned mismatch_count;

    // Idle rates in percent for both sides, and a one-shot request for a long receiver stall.
    int unsigned send_idle_pct;
    int unsigned rcv_idle_pct;
    int unsigned stall_request;
    int unsigned stall_len;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // A hard limit on the whole run; a hang anywhere ends here as a failure.
    initial begin
        #2_000_000;
        $display("[cartridge_bank_mapper] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction of the mapper.
    // ------------------------------------------------------------------------

    // Bank counts above the supported maximum behave as the maximum.
    function automatic logic [9:0] rom_limit();
        return (cfg_m.rom_count > MAX_ROM_BANKS) ? MAX_ROM_BANKS : cfg_m.rom_count;
    endfunction

    function automatic logic [4:0] ram_limit();
        return (cfg_m.ram_count > MAX_RAM_BANKS) ? MAX_RAM_BANKS : cfg_m.ram_count;
    endfunction

    // A bank number at or past the count is refused and the old bank stays.
    function automatic logic [1:0] select_rom_page(logic [8:0] n);
        if ({1'b0, n} >= rom_limit()) return ST_BAD_BANK;
        bank_m.rom_page = n;
        return ST_OK;
    endfunction

    // An accepted RAM bank switch asks for a save when battery RAM holds unsaved data.
    function automatic logic [1:0] select_ram_bank(logic [3:0] n);
        if ({1'b0, n} >= ram_limit()) return ST_BAD_BANK;
        if (cfg_m.battery && bank_m.ram_dirty) save_pending = 1'b1;
        bank_m.ram_bank = n;
        return ST_OK;
    endfunction

    function automatic logic [8:0] bank_or_one(logic [8:0] v);
        return (v == 9'd0) ? 9'd1 : v;
    endfunction

    // Register writes below 0x8000, decoded per controller kind; returns the status.
    function automatic logic [1:0] decode_bank_write(logic [15:0] a, logic [7:0] d);
        logic en;
        en = (d[3:0] == RAM_ENABLE_KEY);
        case (cfg_m.kind)
            KIND_MBC1: begin
                if (a < 16'h2000) begin
                    bank_m.ram_enabled = en;
                    return ST_OK;
                end
                if (a < 16'h4000)
                    return select_rom_page((bank_m.rom_page & 9'h1E0) |
                                           bank_or_one({4'b0, d[4:0]}));
                if (a < 16'h6000) begin
                    // The upper register only acts in advanced mode: RAM bank on the
                    // 32K RAM size, else ROM bits 6:5 on large ROMs.
                    if (!bank_m.advanced_mode) return ST_OK;
                    if (ram_limit() == 5'd4) return select_ram_bank({2'b0, d[1:0]});
                    if (rom_limit() > 10'd32)
                        return select_rom_page((bank_m.rom_page & 9'h19F) |
                                               {2'b0, d[1:0], 5'b0});
                    return ST_OK;
                end
                bank_m.advanced_mode = d[0];
                if (d[0] && ram_limit() == 5'd4) return select_ram_bank({2'b0, d[1:0]});
                return ST_OK;
            end
            KIND_MBC2: begin
                if (a >= 16'h4000) return ST_OK;
                if (a[8]) return select_rom_page(bank_or_one({5'b0, d[3:0]}));
                bank_m.ram_enabled = en;
                return ST_OK;
            end
            KIND_MBC3: begin
                if (a < 16'h2000) begin
                    bank_m.ram_enabled = en;
                    return ST_OK;
                end
                if (a < 16'h4000) return select_rom_page(bank_or_one({2'b0, d[6:0]}));
                // Clock register selects (0x08 and up) are not modeled and do nothing.
                if (a < 16'h6000 && d <= 8'd3) return select_ram_bank(d[3:0]);
                return ST_OK;
            end
            KIND_MBC5: begin
                if (a < 16'h2000) begin
                    bank_m.ram_enabled = en;
                    return ST_OK;
                end
                // MBC5 takes a zero ROM bank as it is.
                if (a < 16'h3000) return select_rom_page({bank_m.rom_page[8], d});
                if (a < 16'h4000) return select_rom_page({d[0], bank_m.rom_page[7:0]});
                if (a < 16'h6000) return select_ram_bank(d[3:0]);
                return ST_OK;
            end
            default: return ST_OK;
        endcase
    endfunction

    // Predicts the result of one accepted access and applies its side effects.
    function automatic t_result map_access(t_access acc);
        t_result r;
        logic    live;
        r = '0;
        save_pending = 1'b0;
        if (!acc.bus_address[15]) begin
            if (acc.mode == MODE_WRITE) begin
                r.status = decode_bank_write(acc.bus_address, acc.write_data);
            end else begin
                r.target = TGT_ROM_READ;
                r.phys_address = acc.bus_address[14] ?
                                 {bank_m.rom_page, acc.bus_address[13:0]} :
                                 {7'b0, acc.bus_address};
            end
        end else if (acc.bus_address[15:13] == 3'b101) begin
            live = bank_m.ram_enabled && (ram_limit() != 5'd0);
            if (!live) begin
                r.target = (acc.mode == MODE_WRITE) ? TGT_NONE : TGT_OPEN_BUS;
            end else begin
                r.phys_address = {6'b0, bank_m.ram_bank, acc.bus_address[12:0]};
                if (acc.mode == MODE_WRITE) begin
                    r.target = TGT_RAM_WRITE;
                    r.ram_write_byte = acc.write_data;
                    if (cfg_m.battery) bank_m.ram_dirty = 1'b1;
                end else begin
                    r.target = TGT_RAM_READ;
                end
            end
        end else begin
            r.status = ST_OUT_BOUND;
        end
        r.save_request = save_pending;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver and checker.
    // ------------------------------------------------------------------------

    // The receiver drops ready at random. A stall request holds it low for a counted
    // stretch, long enough for both internal registers to fill and the input to stall.
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request != 0) begin
                stall_len = stall_request;
                stall_request = 0;
                res_if.ready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
            res_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    function automatic void check_field(string name, logic [22:0] want_v, logic [22:0] got_v);
        if (got_v !== want_v) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
        end
    endfunction

    // Every accepted result request is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got.target         = res_if.target;
            got.phys_address   = res_if.phys_address;
            got.ram_write_byte = res_if.ram_write_byte;
            got.status         = res_if.status;
            got.save_request   = res_if.save_request;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t ns: result with none expected: target %0d addr 0x%0h",
                             $time, got.target, got.phys_address);
            end else begin
                want = expected_results.pop_front();
                check_field("target", 23'(want.target), 23'(got.target));
                check_field("phys_address", want.phys_address, got.phys_address);
                check_field("ram_write_byte", 23'(want.ram_write_byte),
                            23'(got.ram_write_byte));
                check_field("status", 23'(want.status), 23'(got.status));
                check_field("save_request", 23'(want.save_request),
                            23'(got.save_request));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender, configuration and draining.
    // ------------------------------------------------------------------------

    // Offers one access request after a random gap and predicts it when it is taken.
    // Valid stays high into the next call when that call has no gap.
    task automatic send_access(input logic m, input logic [15:0] a, input logic [7:0] d);
        int unsigned gap;
        t_access     item;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap != 0) begin
            acc_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        acc_if.valid       <= 1'b1;
        acc_if.mode        <= m;
        acc_if.bus_address <= a;
        acc_if.write_data  <= d;
        do @(posedge i_clk); while (acc_if.ready !== 1'b1);
        item.mode        = m;
        item.bus_address = a;
        item.write_data  = d;
        expected_results.push_back(map_access(item));
    endtask

    // Stops offering and waits until every predicted result has come back, then lets the
    // pipeline settle. Registers are only written after this.
    task automatic drain_results();
        acc_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all four registers, one per cycle, and mirrors them into the prediction.
    task automatic set_config(input logic [2:0] kind, input logic [9:0] rom,
                              input logic [4:0] ram, input logic bat);
        logic [1:0] idx  [0:3];
        logic [9:0] vals [0:3];
        idx[0] = CFG_KIND;      vals[0] = {7'b0, kind};
        idx[1] = CFG_ROM_COUNT; vals[1] = rom;
        idx[2] = CFG_RAM_COUNT; vals[2] = {5'b0, ram};
        idx[3] = CFG_BATTERY;   vals[3] = {9'b0, bat};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_m.kind      = kind;
        cfg_m.rom_count = rom;
        cfg_m.ram_count = ram;
        cfg_m.battery   = bat;
    endtask

    // Random access, weighted toward well-formed bank programming and mapped accesses
    // so that banking state gets deep; the rest is out-of-bound and raw noise.
    function automatic t_access random_access();
        t_access     a;
        int unsigned pick;
        a.mode        = 1'($urandom_range(0, 1));
        a.bus_address = 16'($urandom);
        a.write_data  = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            a.mode = MODE_WRITE;
            a.bus_address[15] = 1'b0;
            case ($urandom_range(0, 5))
                0: begin
                    // RAM enable write that hits the enable area of every kind.
                    a.bus_address[14:13] = 2'b00;
                    a.bus_address[8]     = 1'b0;
                    a.write_data[3:0]    = RAM_ENABLE_KEY;
                end
                1: a.write_data = 8'($urandom_range(0, 3));
                2: a.write_data = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
                3: a.write_data[3:0] = RAM_ENABLE_KEY;
                default: ;
            endcase
        end else if (pick < 60) begin
            a.mode = MODE_READ;
            a.bus_address[15] = 1'b0;
        end else if (pick < 88) begin
            a.bus_address[15:13] = 3'b101;
        end else if (pick < 95) begin
            a.bus_address[15] = 1'b1;
            if (a.bus_address[15:13] == 3'b101) a.bus_address[13] = 1'b0;
        end
        return a;
    endfunction

    task automatic pick_random_config();
        logic [2:0] kind;
        logic [9:0] rom;
        logic [4:0] ram;
        kind = ($urandom_range(0, 19) == 0) ? KIND_UNUSED : 3'($urandom_range(0, 4));
        case ($urandom_range(0, 7))
            0: rom = 10'd2;
            1: rom = 10'd8;
            2: rom = 10'd32;
            3: rom = 10'd33;
            4: rom = 10'd128;
            5: rom = MAX_ROM_BANKS;
            default: rom = 10'($urandom_range(2, 512));
        endcase
        case ($urandom_range(0, 7))
            0: ram = 5'd0;
            1: ram = 5'd1;
            2: ram = 5'd2;
            3, 4: ram = 5'd4;
            5: ram = 5'd8;
            6: ram = MAX_RAM_BANKS;
            default: ram = 5'($urandom_range(0, 16));
        endcase
        set_config(kind, rom, ram, 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Reset configuration: plain ROM, no RAM, register writes ignored.
    task automatic test_no_banking();
        send_access(MODE_READ,  16'h0000, 8'hFF);
        send_access(MODE_READ,  16'h7FFF, 8'h00);
        send_access(MODE_WRITE, 16'h2000, 8'h05);
        send_access(MODE_READ,  16'hA000, 8'h3C);
        send_access(MODE_READ,  16'h8000, 8'h00);
        send_access(MODE_WRITE, 16'hFFFF, 8'hFF);
        drain_results();
    endtask

    // MBC1 with the 32K RAM size: zero bank becomes bank 1, advanced mode picks the
    // RAM bank, and a switch after a battery-backed write requests a save.
    task automatic test_mbc1_banking();
        set_config(KIND_MBC1, 10'd64, 5'd4, 1'b1);
        send_access(MODE_WRITE, 16'h0000, 8'h0A);
        send_access(MODE_WRITE, 16'h2000, 8'h00);
        send_access(MODE_WRITE, 16'h3FFF, 8'h1F);
        send_access(MODE_WRITE, 16'h6000, 8'h01);
        send_access(MODE_WRITE, 16'hBFFF, 8'h5A);
        send_access(MODE_WRITE, 16'h4000, 8'h02);
        send_access(MODE_READ,  16'hBFFF, 8'h00);
        send_access(MODE_READ,  16'h4000, 8'h00);
        drain_results();
    endtask

    // MBC5 at the largest sizes: full 9-bit ROM bank, a zero low byte kept as it is, top RAM bank.
    task automatic test_mbc5_wide_banks();
        set_config(KIND_MBC5, MAX_ROM_BANKS, MAX_RAM_BANKS, 1'b1);
        send_access(MODE_WRITE, 16'h2000, 8'hFF);
        send_access(MODE_WRITE, 16'h3000, 8'h01);
        send_access(MODE_WRITE, 16'h4000, 8'h0F);
        send_access(MODE_READ,  16'h7FFF, 8'h00);
        send_access(MODE_WRITE, 16'h2FFF, 8'h00);
        drain_results();
    endtask

    // MBC3 on the smallest ROM: out-of-range banks are refused, clock selects ignored.
    task automatic test_mbc3_rejects();
        set_config(KIND_MBC3, 10'd2, 5'd2, 1'b0);
        send_access(MODE_WRITE, 16'h2000, 8'h7F);
        send_access(MODE_WRITE, 16'h4000, 8'h08);
        send_access(MODE_WRITE, 16'h5FFF, 8'h03);
        send_access(MODE_WRITE, 16'h2000, 8'h00);
        drain_results();
    endtask

    // MBC2: address bit 8 splits ROM bank select from RAM enable; disabled RAM reads
    // the open bus and swallows writes.
    task automatic test_mbc2_ram_disable();
        set_config(KIND_MBC2, 10'd16, 5'd1, 1'b0);
        send_access(MODE_WRITE, 16'h0100, 8'h00);
        send_access(MODE_WRITE, 16'h0000, 8'h0B);
        send_access(MODE_READ,  16'hA123, 8'h00);
        send_access(MODE_WRITE, 16'hA123, 8'h77);
        drain_results();
    endtask

    // An undefined controller kind with counts past the maximum ignores every write.
    task automatic test_unused_kind();
        set_config(KIND_UNUSED, 10'h3FF, 5'h1F, 1'b1);
        send_access(MODE_WRITE, 16'h2000, 8'h05);
        send_access(MODE_READ,  16'h4000, 8'h00);
        drain_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering, so the
    // block fills and stalls its input; afterward the sender waits for a full drain.
    task automatic test_backpressure();
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        set_config(KIND_MBC5, MAX_ROM_BANKS, MAX_RAM_BANKS, 1'b1);
        stall_request = 60;
        repeat (24) begin
            t_access a;
            a = random_access();
            send_access(a.mode, a.bus_address, a.write_data);
        end
        drain_results();
    endtask

    // Random traffic over several random configurations at one pair of idle rates.
    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned rcv_pct,
                                       input int unsigned phases, input int unsigned items);
        t_access a;
        send_idle_pct = send_pct;
        rcv_idle_pct  = rcv_pct;
        repeat (phases) begin
            pick_random_config();
            repeat (items) begin
                a = random_access();
                send_access(a.mode, a.bus_address, a.write_data);
            end
            drain_results();
        end
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= CFG_KIND;
        i_cfg_data         <= '0;
        acc_if.valid       <= 1'b0;
        acc_if.mode        <= MODE_READ;
        acc_if.bus_address <= '0;
        acc_if.write_data  <= '0;
        mismatch_count = 0;
        stall_request  = 0;
        send_idle_pct  = 35;
        rcv_idle_pct   = 84;
        cfg_m  = '{kind: KIND_NONE, rom_count: 10'd2, ram_count: 5'd0, battery: 1'b0};
        bank_m = '{ram_enabled: 1'b0, rom_page: 9'd1, ram_bank: 4'd0,
                   advanced_mode: 1'b0, ram_dirty: 1'b0};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_no_banking();
        test_mbc1_banking();
        test_mbc5_wide_banks();
        test_mbc3_rejects();
        test_mbc2_ram_disable();
        test_unused_kind();
        test_backpressure();
        test_random_traffic(35, 84, 6, 45);
        test_random_traffic(84, 35, 6, 45);
        test_random_traffic(0, 0, 6, 45);

        drain_results();
        if (mismatch_count == 0) begin
            $display("[cartridge_bank_mapper] OK");
        end else begin
            $display("[cartridge_bank_mapper] ERROR");
        end
        $finish;
    end

endmodule
